// ----- design/sss_pkg.sv -----
package sss_pkg;

   // register index, taken from csr_paddr[2]
   localparam logic REG_KINETIC_GAIN = 1'b0;
   localparam logic REG_TIME_STEP    = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_RATE,
      S_ROUND,
      S_TERM,
      S_KIN,
      S_SUM,
      S_PASS
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RATE,
      OP_ROUND,
      OP_TERM,
      OP_KIN
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
      logic      load_calc;
      logic      load_pass;
      logic      win_shift;
      logic      win_clear;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } dp_sts_type;

endpackage

// ----- design/schrodinger_stencil_step_unit.sv -----
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: real, imag, potential; tlast: last sample
// rsp_      out  rsp_tvalid/rsp_tready  tdata: out_real, out_imag; tlast: last result
// csr_      in   psel/penable/pready    kinetic_gain @0x0, time_step @0x4
//
// One grid point at a time. Edge points are passed through; a second point is held.
// An interior point goes through accept, decide, then rate, round, term and
// kinetic steps through the two shared multipliers, then the sum into the output.
// A row-ending point after an interior one gives two words: the centre's result, then itself.
// Synchronous active-high reset clears the controller, output valid and the CSR registers.
// A stalled output holds the controller in its load state; input waits meanwhile.
module schrodinger_stencil_step_unit
   import sss_pkg::*;
#(
   parameter int AMP_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // stream in
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // real_part, imag_part, potential, zero pad
   input  logic [((2*AMP_WIDTH+23)/8)*8-1:0]      req_tdata,
   // last_sample
   input  logic                                   req_tlast,
   // stream out
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_real, out_imag, zero pad
   output logic [((2*AMP_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   // last_result
   output logic                                   rsp_tlast,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [2:0]                             csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int RSP_W = ((2*AMP_WIDTH+7)/8)*8;

   logic [15:0]                 kinetic_gain_ff;
   logic [31:0]                 time_step_ff;
   logic                        csr_write;
   dp_cmd_type                  dp_cmd;
   dp_sts_type                  dp_sts;
   logic signed [AMP_WIDTH-1:0] out_real, out_imag;

   // register port: zero wait state
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kinetic_gain_ff <= '0;
         time_step_ff    <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_TIME_STEP) begin
            time_step_ff <= csr_pwdata;
         end else begin
            kinetic_gain_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TIME_STEP) ? time_step_ff
                                                       : {16'd0, kinetic_gain_ff};

   sss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   sss_datapath #(
      .AMP_WIDTH (AMP_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_real      (signed'(req_tdata[AMP_WIDTH-1:0])),
      .in_imag      (signed'(req_tdata[2*AMP_WIDTH-1:AMP_WIDTH])),
      .in_potential (req_tdata[2*AMP_WIDTH+15:2*AMP_WIDTH]),
      .in_last      (req_tlast),
      .kinetic_gain (kinetic_gain_ff),
      .time_step    (time_step_ff),
      .cmd          (dp_cmd),
      .sts          (dp_sts),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .out_real     (out_real),
      .out_imag     (out_imag),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({out_imag, out_real});

`ifndef SYNTHESIS
   // one point in flight: a new word is never taken the cycle after one is
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while previous point in progress");

   // a result word is only loaded where the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.load_calc || dp_cmd.load_pass) |-> (!rsp_tvalid || rsp_tready))
      else $error("untaken result word overwritten");

   // the window is cleared only together with the row-ending word
   a_clear_with_last: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.win_clear |-> (dp_cmd.load_pass && dp_sts.last))
      else $error("window cleared outside row end");
`endif

endmodule

// ----- design/sss_ctrl.sv -----
module sss_ctrl
   import sss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     seen_ff, seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seen_ff  <= SEEN_NONE;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      seen_in       = seen_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.op        = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (seen_ff)
               SEEN_NONE: state_in = S_PASS;
               SEEN_ONE: begin
                  if (sts.last) begin
                     state_in = S_PASS;
                  end else begin
                     cmd.win_shift = 1'b1;
                     seen_in       = SEEN_TWO;
                     state_in      = S_IDLE;
                  end
               end
               default: state_in = S_RATE;
            endcase
         end
         S_RATE: begin
            cmd.op   = OP_RATE;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = S_TERM;
         end
         S_TERM: begin
            cmd.op   = OP_TERM;
            state_in = S_KIN;
         end
         S_KIN: begin
            cmd.op   = OP_KIN;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sts.out_free) begin
               cmd.load_calc = 1'b1;
               if (sts.last) begin
                  state_in = S_PASS;
               end else begin
                  cmd.win_shift = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_PASS: begin
            if (sts.out_free) begin
               cmd.load_pass = 1'b1;
               state_in      = S_IDLE;
               if (sts.last) begin
                  cmd.win_clear = 1'b1;
                  seen_in       = SEEN_NONE;
               end else begin
                  cmd.win_shift = 1'b1;
                  seen_in       = SEEN_ONE;
               end
            end
         end
      endcase
   end

endmodule

// ----- design/sss_datapath.sv -----
module sss_datapath
   import sss_pkg::*;
#(
   parameter int AMP_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [AMP_WIDTH-1:0] in_real,
   input  logic signed [AMP_WIDTH-1:0] in_imag,
   input  logic [15:0]                 in_potential,
   input  logic                        in_last,
   input  logic [15:0]                 kinetic_gain,
   input  logic [31:0]                 time_step,
   input  dp_cmd_type                  cmd,
   output dp_sts_type                  sts,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [AMP_WIDTH-1:0] out_real,
   output logic signed [AMP_WIDTH-1:0] out_imag,
   output logic                        out_last
);

   localparam int LW = AMP_WIDTH + 2;          // laplacian
   localparam int BW = (LW > 17) ? LW : 17;    // multiplier B operand
   localparam int PW = 33 + BW;                // product
   localparam int SW = PW + 1;                 // accumulator
   localparam int QW = SW - 16;                // after dropping fraction bits

   localparam logic signed [AMP_WIDTH-1:0] AMP_MAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
   localparam logic signed [AMP_WIDTH-1:0] AMP_MIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};
   localparam logic signed [SW-1:0]        HALF    = SW'(32'sd32768);

   logic signed [AMP_WIDTH-1:0] in_re_ff, in_im_ff;
   logic [15:0]                 in_pot_ff;
   logic                        in_last_ff;
   logic signed [AMP_WIDTH-1:0] win_re_ff [2];
   logic signed [AMP_WIDTH-1:0] win_im_ff [2];
   logic [15:0]                 pot_ff;

   logic signed [LW-1:0]  lap_r, lap_i;
   logic signed [32:0]    mul_a;
   logic signed [BW-1:0]  mul_b0, mul_b1;
   logic signed [PW-1:0]  prod0_in, prod1_in;
   logic signed [PW-1:0]  prod0_ff, prod1_ff;
   logic signed [PW-1:0]  term_r_cl, term_i_cl;
   logic [48:0]           rate_sum;
   logic [31:0]           rate_ff;
   logic signed [SW-1:0]  acc_r_ff, acc_i_ff;
   logic signed [SW-1:0]  fin_r, fin_i;

   logic                        rsp_valid_ff;
   logic signed [AMP_WIDTH-1:0] rsp_re_ff, rsp_im_ff;
   logic                        rsp_last_ff;

   // floor of t / 2^16 (half already added), clamped to the amplitude range
   function automatic logic signed [AMP_WIDTH-1:0] round_sat(input logic signed [SW-1:0] t);
      logic signed [QW-1:0]        q;
      logic [QW-AMP_WIDTH:0]       hi;
      logic signed [AMP_WIDTH-1:0] r;
      q  = t[SW-1:16];
      hi = q[QW-1:AMP_WIDTH-1];
      if ((&hi) || !(|hi)) begin
         r = q[AMP_WIDTH-1:0];
      end else if (q[QW-1]) begin
         r = AMP_MIN;
      end else begin
         r = AMP_MAX;
      end
      return r;
   endfunction

   // three-point laplacians: left - 2*centre + right
   assign lap_r = LW'(win_re_ff[0]) - (LW'(win_re_ff[1]) <<< 1) + LW'(in_re_ff);
   assign lap_i = LW'(win_im_ff[0]) - (LW'(win_im_ff[1]) <<< 1) + LW'(in_im_ff);

   // two multipliers sharing the A operand
   always_comb begin
      mul_a  = '0;
      mul_b0 = '0;
      mul_b1 = '0;
      unique case (cmd.op)
         OP_RATE: begin
            mul_a  = signed'({1'b0, time_step});
            mul_b0 = BW'(signed'({1'b0, pot_ff}));
         end
         OP_TERM: begin
            mul_a  = signed'({1'b0, rate_ff});
            mul_b0 = BW'(win_im_ff[1]);
            mul_b1 = BW'(win_re_ff[1]);
         end
         OP_KIN: begin
            mul_a  = signed'({17'd0, kinetic_gain});
            mul_b0 = BW'(lap_i);
            mul_b1 = BW'(lap_r);
         end
         default: begin
            mul_a  = '0;
         end
      endcase
   end

   assign prod0_in = mul_a * mul_b0;
   assign prod1_in = mul_a * mul_b1;

   // rate*amp terms are limited to +-2^62; only reachable at wide amplitudes
   if (PW > 63) begin : g_clamp
      localparam logic signed [PW-1:0] TERM_LIM = signed'(PW'(1) << 62);
      always_comb begin
         term_r_cl = prod0_ff;
         if (prod0_ff > TERM_LIM) begin
            term_r_cl = TERM_LIM;
         end else if (prod0_ff < -TERM_LIM) begin
            term_r_cl = -TERM_LIM;
         end
         term_i_cl = prod1_ff;
         if (prod1_ff > TERM_LIM) begin
            term_i_cl = TERM_LIM;
         end else if (prod1_ff < -TERM_LIM) begin
            term_i_cl = -TERM_LIM;
         end
      end
   end else begin : g_noclamp
      assign term_r_cl = prod0_ff;
      assign term_i_cl = prod1_ff;
   end

   assign rate_sum = {1'b0, prod0_ff[47:0]} + 49'd32768;

   assign fin_r = acc_r_ff + SW'(prod0_ff) + HALF;
   assign fin_i = acc_i_ff - SW'(prod1_ff) + HALF;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_re_ff   <= in_real;
         in_im_ff   <= in_imag;
         in_pot_ff  <= in_potential;
         in_last_ff <= in_last;
      end
      if (cmd.op == OP_RATE || cmd.op == OP_TERM || cmd.op == OP_KIN) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
      end
      if (cmd.op == OP_ROUND) begin
         rate_ff <= rate_sum[47:16];
      end
      if (cmd.op == OP_KIN) begin
         acc_r_ff <= (SW'(win_re_ff[1]) <<< 16) - SW'(term_r_cl);
         acc_i_ff <= (SW'(win_im_ff[1]) <<< 16) + SW'(term_i_cl);
      end
      if (cmd.win_clear) begin
         win_re_ff[0] <= '0;
         win_re_ff[1] <= '0;
         win_im_ff[0] <= '0;
         win_im_ff[1] <= '0;
         pot_ff       <= '0;
      end else if (cmd.win_shift) begin
         win_re_ff[0] <= win_re_ff[1];
         win_im_ff[0] <= win_im_ff[1];
         win_re_ff[1] <= in_re_ff;
         win_im_ff[1] <= in_im_ff;
         pot_ff       <= in_pot_ff;
      end
      if (cmd.load_calc) begin
         rsp_re_ff   <= round_sat(fin_r);
         rsp_im_ff   <= round_sat(fin_i);
         rsp_last_ff <= 1'b0;
      end else if (cmd.load_pass) begin
         rsp_re_ff   <= in_re_ff;
         rsp_im_ff   <= in_im_ff;
         rsp_last_ff <= in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_calc || cmd.load_pass) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.last     = in_last_ff;

   assign rsp_valid = rsp_valid_ff;
   assign out_real  = rsp_re_ff;
   assign out_imag  = rsp_im_ff;
   assign out_last  = rsp_last_ff;

endmodule
